FILE: rtl/bitmap_zone_allocator_defines.svh
// Assertion macros for the bitmap zone allocator.
`ifndef BITMAP_ZONE_ALLOCATOR_DEFINES_SVH
`define BITMAP_ZONE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define BZA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BZA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bza_pkg.sv
// Package: types, codes and fixed geometry of the bitmap zone allocator.
package bza_pkg;

   localparam int WORD_BITS       = 32;
   localparam int BLOCK_BITS_LOG2 = 13;
   localparam int WORDS_PER_BLOCK = (1 << BLOCK_BITS_LOG2) / WORD_BITS;
   localparam int WIDX_W          = $clog2(WORDS_PER_BLOCK);
   localparam int POS_W           = $clog2(WORD_BITS);

   localparam int BIT_W          = 16;
   localparam int WORD_INDEX_W   = 11;
   localparam int DATA_W         = 32;
   localparam int TOTAL_W        = 17;
   localparam int MAPBLK_W       = 4;
   localparam int FIRST_W        = 16;
   localparam int STATUS_W       = 3;
   localparam int OP_W           = 2;
   localparam int HINT_BLK_W     = BIT_W - BLOCK_BITS_LOG2;
   localparam int WIDX_HI_W      = WORD_INDEX_W - WIDX_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = TOTAL_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_BITS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_BLOCKS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_DATA_BIT = 2'd2;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREE_FREE = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [BIT_W-1:0]        bit_index;
      logic [WORD_INDEX_W-1:0] word_index;
      logic [DATA_W-1:0]       word_data;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BIT_W-1:0]    bit_number;
      logic [DATA_W-1:0]   read_data;
      logic                block_dirty;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FREE,
      S_READ
   } state_type;

   // Verdict of the word evaluator on one map word.
   typedef struct packed {
      logic             full;
      logic             beyond;
      logic             below;
      logic [BIT_W-1:0] bit_number;
      logic [POS_W-1:0] pos;
   } scan_result_type;

endpackage

FILE: rtl/bza_word_scan.sv
// Word evaluator: lowest clear bit of a map word and its range checks.
module bza_word_scan #(
   parameter int BLK_W = 3
) (
   input  logic [bza_pkg::WORD_BITS-1:0] word,
   input  logic [BLK_W-1:0]              blk,
   input  logic [bza_pkg::WIDX_W-1:0]    widx,
   input  logic [bza_pkg::TOTAL_W-1:0]   total_bits,
   input  logic [bza_pkg::FIRST_W-1:0]   first_data_bit,
   output bza_pkg::scan_result_type      result
);
   import bza_pkg::*;

   localparam int RAW_W = BLK_W + BLOCK_BITS_LOG2;
   localparam int A_W   = (RAW_W > TOTAL_W) ? RAW_W : TOTAL_W;

   logic [POS_W-1:0] pos;
   logic [RAW_W-1:0] a_raw;
   logic [A_W-1:0]   a;

   // lowest clear bit wins
   always_comb begin
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            pos = POS_W'(i);
         end
      end
   end

   assign a_raw = {blk, widx, pos};
   assign a     = A_W'(a_raw);

   assign result.full       = &word;
   assign result.beyond     = a >= A_W'(total_bits);
   assign result.below      = a < A_W'(first_data_bit);
   assign result.bit_number = a[BIT_W-1:0];
   assign result.pos        = pos;

endmodule

FILE: rtl/bitmap_zone_allocator.sv
// Top level: bitmap zone allocator with next-fit search over the map memory.
//
//  channel   direction  handshake                 payload
//  req       in         start high, busy low      req_payload (req_type)
//  rsp       out        rsp_strobe, one cycle     rsp_payload (rsp_type)
//  csr       in         csr_write_en              csr_index, csr_data
//
// Load needs no map read; read and free make one map read; allocate evaluates one map
// word per cycle, held by a refill step per block skipped past the total, over up to
// about (blocks in use + 1) * WORDS_PER_BLOCK words; the single registered read port
// of the map memory sets the pace. The result transfer follows in the next cycle.
// Reset clears control, dirty marks, total and first data bit, sets map_blocks to 1;
// map words are undefined until loaded: no clearing pass. The receiver cannot stall.
`include "bitmap_zone_allocator_defines.svh"

module bitmap_zone_allocator #(
   parameter int MAX_MAP_BLOCKS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  bza_pkg::req_type                 req_payload,
   output logic                             rsp_strobe,
   output bza_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_write_en,
   input  logic [bza_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bza_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bza_pkg::*;

   localparam int BLK_W     = (MAX_MAP_BLOCKS > 1) ? $clog2(MAX_MAP_BLOCKS) : 1;
   localparam int MAP_DEPTH = MAX_MAP_BLOCKS * WORDS_PER_BLOCK;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);
   localparam int CNT_W     = $clog2(MAX_MAP_BLOCKS + 2);
   localparam int NB_W      = (CNT_W > MAPBLK_W) ? CNT_W : MAPBLK_W;

   // scan position: block, word within block, blocks left to visit, valid
   typedef struct packed {
      logic [BLK_W-1:0]  blk;
      logic [WIDX_W-1:0] widx;
      logic [CNT_W-1:0]  cnt;
      logic              live;
   } ptr_type;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [BLK_W-1:0]  blk,
                                                   input logic [WIDX_W-1:0] widx);
      logic [BLK_W+WIDX_W-1:0] full;
      full = {blk, widx};
      return full[ADDR_W-1:0];
   endfunction

   function automatic logic [BLK_W-1:0] next_block(input logic [BLK_W-1:0] blk,
                                                   input logic [CNT_W-1:0] nb);
      logic [NB_W-1:0] b1;
      b1 = NB_W'(blk) + NB_W'(1);
      return (b1 == NB_W'(nb)) ? '0 : BLK_W'(b1);
   endfunction

   function automatic ptr_type advance(input ptr_type p, input logic [CNT_W-1:0] nb);
      ptr_type q;
      q = p;
      if (p.widx == WIDX_W'(WORDS_PER_BLOCK - 1)) begin
         q.blk  = next_block(p.blk, nb);
         q.widx = '0;
         q.cnt  = p.cnt - CNT_W'(1);
         q.live = (p.cnt != CNT_W'(1));
      end else begin
         q.widx = p.widx + WIDX_W'(1);
         q.live = 1'b1;
      end
      return q;
   endfunction

   // control and configuration state
   state_type                 state_ff, state_in;
   logic [TOTAL_W-1:0]        total_bits_ff, total_bits_in;
   logic [MAPBLK_W-1:0]       map_blocks_ff, map_blocks_in;
   logic [FIRST_W-1:0]        first_data_bit_ff, first_data_bit_in;
   logic [MAX_MAP_BLOCKS-1:0] dirty_ff, dirty_in;
   ptr_type                   chk_ff, chk_in;
   ptr_type                   iss_ff, iss_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;

   // payload state
   rsp_type                   rsp_ff, rsp_in;
   logic [BLK_W-1:0]          free_blk_ff, free_blk_in;
   logic [WIDX_W-1:0]         free_widx_ff, free_widx_in;
   logic [POS_W-1:0]          free_pos_ff, free_pos_in;
   logic [BLK_W-1:0]          read_blk_ff, read_blk_in;

   // map memory
   logic [WORD_BITS-1:0]      map_mem [MAP_DEPTH];
   logic [WORD_BITS-1:0]      rdata_ff;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [WORD_BITS-1:0]      mem_wdata;
   logic [ADDR_W-1:0]         mem_raddr;

   // decode
   logic [NB_W-1:0]           mb_ext, nblk_ext, req_hb, hint_hb, bmod;
   logic [CNT_W-1:0]          nblk;
   logic [BIT_W-1:0]          hint;
   ptr_type                   start_ptr;
   logic                      free_ok;
   logic [ADDR_W-1:0]         req_raddr;
   logic                      chk_last;
   logic                      scan_done;
   scan_result_type           sr;
   logic [WORD_BITS-1:0]      chk_mask, free_mask;

   // blocks in use, clamped to 1 .. MAX_MAP_BLOCKS
   always_comb begin
      mb_ext = NB_W'(map_blocks_ff);
      if (mb_ext == '0) begin
         nblk_ext = NB_W'(1);
      end else if (mb_ext > NB_W'(MAX_MAP_BLOCKS)) begin
         nblk_ext = NB_W'(MAX_MAP_BLOCKS);
      end else begin
         nblk_ext = mb_ext;
      end
      nblk = CNT_W'(nblk_ext);
   end

   // start of the search: hint past the map, or outside the blocks in use, goes to 0
   always_comb begin
      hint    = (TOTAL_W'(req_payload.bit_index) >= total_bits_ff) ? '0
                                                                     : req_payload.bit_index;
      hint_hb = NB_W'(hint[BIT_W-1:BLOCK_BITS_LOG2]);
      start_ptr.live = 1'b1;
      if (hint_hb >= NB_W'(nblk)) begin
         start_ptr.blk  = '0;
         start_ptr.widx = '0;
      end else begin
         start_ptr.blk  = BLK_W'(hint_hb);
         start_ptr.widx = hint[BLOCK_BITS_LOG2-1 -: WIDX_W];
      end
      // a mid-block start revisits its own block from word 0 at the end
      start_ptr.cnt = (start_ptr.widx == '0) ? nblk : nblk + CNT_W'(1);
   end

   // range checks for free
   always_comb begin
      req_hb  = NB_W'(req_payload.bit_index[BIT_W-1:BLOCK_BITS_LOG2]);
      free_ok = (req_payload.bit_index >= first_data_bit_ff) &&
                (TOTAL_W'(req_payload.bit_index) < total_bits_ff) &&
                (req_hb < NB_W'(nblk));
   end

   // word index wraps modulo the map depth: only the block part needs reducing
   always_comb begin
      bmod = NB_W'(req_payload.word_index[WORD_INDEX_W-1:WIDX_W]);
      for (int k = 0; k < (1 << WIDX_HI_W); k++) begin
         if (bmod >= NB_W'(MAX_MAP_BLOCKS)) begin
            bmod = bmod - NB_W'(MAX_MAP_BLOCKS);
         end
      end
   end

   always_comb begin
      unique case (req_payload.operation)
         OP_ALLOC: req_raddr = word_addr(start_ptr.blk, start_ptr.widx);
         OP_FREE:  req_raddr = word_addr(BLK_W'(req_hb),
                      req_payload.bit_index[BLOCK_BITS_LOG2-1 -: WIDX_W]);
         OP_LOAD:  req_raddr = word_addr(BLK_W'(bmod), req_payload.word_index[WIDX_W-1:0]);
         OP_READ:  req_raddr = word_addr(BLK_W'(bmod), req_payload.word_index[WIDX_W-1:0]);
      endcase
   end

   // word evaluator for the allocate scan, fed by the registered memory read
   bza_word_scan #(
      .BLK_W(BLK_W)
   ) u_word_scan (
      .word           (rdata_ff),
      .blk            (chk_ff.blk),
      .widx           (chk_ff.widx),
      .total_bits     (total_bits_ff),
      .first_data_bit (first_data_bit_ff),
      .result         (sr)
   );

   assign chk_last  = (chk_ff.widx == WIDX_W'(WORDS_PER_BLOCK - 1)) &&
                      (chk_ff.cnt == CNT_W'(1));
   assign scan_done = chk_ff.live &&
                      ((sr.full && chk_last) ||
                       (!sr.full && (!sr.beyond || chk_ff.cnt == CNT_W'(1))));
   assign chk_mask  = WORD_BITS'(1) << sr.pos;
   assign free_mask = WORD_BITS'(1) << free_pos_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_payload.operation)
                  OP_ALLOC: state_in = S_SCAN;
                  OP_FREE:  state_in = (req_payload.bit_index != '0 && free_ok) ? S_FREE
                                                                                 : S_IDLE;
                  OP_LOAD:  state_in = S_IDLE;
                  OP_READ:  state_in = S_READ;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_IDLE;
            end
         end
         S_FREE:  state_in = S_IDLE;
         S_READ:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs of the sequencer
   always_comb begin
      total_bits_in     = total_bits_ff;
      map_blocks_in     = map_blocks_ff;
      first_data_bit_in = first_data_bit_ff;
      dirty_in          = dirty_ff;
      chk_in            = chk_ff;
      iss_in            = iss_ff;
      free_blk_in       = free_blk_ff;
      free_widx_in      = free_widx_ff;
      free_pos_in       = free_pos_ff;
      read_blk_in       = read_blk_ff;
      rsp_strobe_in     = 1'b0;
      rsp_in            = rsp_ff;
      mem_we            = 1'b0;
      mem_waddr         = word_addr(chk_ff.blk, chk_ff.widx);
      mem_wdata         = rdata_ff;
      mem_raddr         = word_addr(iss_ff.blk, iss_ff.widx);

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_TOTAL_BITS:     total_bits_in     = csr_data;
            CSR_MAP_BLOCKS:     map_blocks_in     = csr_data[MAPBLK_W-1:0];
            CSR_FIRST_DATA_BIT: first_data_bit_in = csr_data[FIRST_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            mem_raddr = req_raddr;
            if (start) begin
               unique case (req_payload.operation)
                  OP_ALLOC: begin
                     chk_in = start_ptr;
                     iss_in = advance(start_ptr, nblk);
                  end
                  OP_FREE: begin
                     free_blk_in  = BLK_W'(req_hb);
                     free_widx_in = req_payload.bit_index[BLOCK_BITS_LOG2-1 -: WIDX_W];
                     free_pos_in  = req_payload.bit_index[POS_W-1:0];
                     if (req_payload.bit_index == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = '0;
                        rsp_in.status = STATUS_IGNORED;
                     end else if (!free_ok) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = '0;
                        rsp_in.status = STATUS_INVALID;
                     end
                  end
                  OP_LOAD: begin
                     mem_we        = 1'b1;
                     mem_waddr     = req_raddr;
                     mem_wdata     = req_payload.word_data[WORD_BITS-1:0];
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '0;
                     rsp_in.status = STATUS_OK;
                  end
                  OP_READ: begin
                     read_blk_in = BLK_W'(bmod);
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!chk_ff.live) begin
               // refill after a block skip
               chk_in = iss_ff;
               iss_in = advance(iss_ff, nblk);
            end else if (sr.full) begin
               if (chk_last) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  rsp_in.status = STATUS_NO_SPACE;
               end else begin
                  chk_in = iss_ff;
                  iss_in = advance(iss_ff, nblk);
               end
            end else if (sr.beyond) begin
               // clear bit at or past the total: rest of this block is dead
               if (chk_ff.cnt == CNT_W'(1)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
                  rsp_in.status = STATUS_NO_SPACE;
               end else begin
                  iss_in.blk  = next_block(chk_ff.blk, nblk);
                  iss_in.widx = '0;
                  iss_in.cnt  = chk_ff.cnt - CNT_W'(1);
                  iss_in.live = 1'b1;
                  chk_in.live = 1'b0;
               end
            end else begin
               dirty_in[chk_ff.blk] = 1'b1;
               rsp_strobe_in        = 1'b1;
               rsp_in               = '0;
               if (sr.below) begin
                  // taken and given back at once: word unchanged, block still dirty
                  rsp_in.status = STATUS_NO_SPACE;
               end else begin
                  mem_we            = 1'b1;
                  mem_wdata         = rdata_ff | chk_mask;
                  rsp_in.status     = STATUS_OK;
                  rsp_in.bit_number = sr.bit_number;
               end
            end
         end
         S_FREE: begin
            rsp_strobe_in = 1'b1;
            rsp_in        = '0;
            if ((rdata_ff & free_mask) == '0) begin
               rsp_in.status = STATUS_FREE_FREE;
            end else begin
               mem_we                = 1'b1;
               mem_waddr             = word_addr(free_blk_ff, free_widx_ff);
               mem_wdata             = rdata_ff & ~free_mask;
               dirty_in[free_blk_ff] = 1'b1;
               rsp_in.status         = STATUS_OK;
            end
         end
         S_READ: begin
            rsp_strobe_in         = 1'b1;
            rsp_in                = '0;
            rsp_in.status         = STATUS_OK;
            rsp_in.read_data      = DATA_W'(rdata_ff);
            rsp_in.block_dirty    = dirty_ff[read_blk_ff];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         total_bits_ff     <= '0;
         map_blocks_ff     <= MAPBLK_W'(1);
         first_data_bit_ff <= '0;
         dirty_ff          <= '0;
         chk_ff            <= '0;
         iss_ff            <= '0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         state_ff          <= state_in;
         total_bits_ff     <= total_bits_in;
         map_blocks_ff     <= map_blocks_in;
         first_data_bit_ff <= first_data_bit_in;
         dirty_ff          <= dirty_in;
         chk_ff            <= chk_in;
         iss_ff            <= iss_in;
         rsp_strobe_ff     <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      free_blk_ff  <= free_blk_in;
      free_widx_ff <= free_widx_in;
      free_pos_ff  <= free_pos_in;
      read_blk_ff  <= read_blk_in;
   end

   // map memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= map_mem[mem_raddr];
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   `BZA_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_strobe, !busy, "result while busy")
   `BZA_ASSERT_NEXT(a_accept_moves, clock, reset, start && !busy, busy || rsp_strobe, "transfer dropped")
   `BZA_ASSERT_NOW(a_finish_strobe, clock, reset, $fell(busy) && !$past(reset), rsp_strobe, "no result at end")
   `BZA_ASSERT_NOW(a_alloc_in_map, clock, reset, rsp_strobe && rsp_payload.bit_number != '0, (rsp_payload.status == STATUS_OK) && (TOTAL_W'(rsp_payload.bit_number) < total_bits_ff), "bit past total")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for bitmap_zone_allocator: queued command driver, result monitor, shadow map.
module tb_top;
   import bza_pkg::*;

   localparam int BLOCKS_MAX  = 8;
   localparam int MAP_WORDS   = BLOCKS_MAX * WORDS_PER_BLOCK;
   // Worst allocate: every word of every block in use plus the start block again.
   localparam int SCAN_CYCLES = (BLOCKS_MAX + 1) * WORDS_PER_BLOCK + 64;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_CMDS  = 42;
   localparam logic [DATA_W-1:0] FULL_WORD = '1;

   typedef struct {
      req_type cmd;
      bit      hold;   // hold off until every outstanding result has arrived
   } pending_cmd_type;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   start        = 1'b0;
   logic                   busy;
   req_type                req_payload  = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_payload;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_data     = '0;

   // Commands waiting for their request transfer, and outcomes waiting for theirs.
   pending_cmd_type cmd_queue[$];
   rsp_type         awaited_outcomes[$];

   // Shadow copy of the allocator: bitmap, dirty marks and registers.
   logic [DATA_W-1:0]   shadow_map [MAP_WORDS];
   bit                  shadow_dirty [BLOCKS_MAX];
   logic [TOTAL_W-1:0]  reg_total  = '0;
   logic [MAPBLK_W-1:0] reg_blocks = MAPBLK_W'(1);
   logic [FIRST_W-1:0]  reg_first  = '0;

   int     error_count = 0;
   longint cycle_count = 0;
   longint cycle_limit = 2000;
   bit     idling_on   = 1'b0;
   bit     just_taken  = 1'b0;
   int     gap_left    = 0;

   bitmap_zone_allocator #(
      .MAX_MAP_BLOCKS(BLOCKS_MAX)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .rsp_strobe   (rsp_strobe),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   // Outcome of one command against the shadow state; updates the shadow as the block would.
   function automatic rsp_type zone_outcome(req_type cmd);
      rsp_type           outcome;
      int                nblk, hint, blk, w, count, pos, spot, addr;
      bit                found, skip;
      logic [DATA_W-1:0] word;
      outcome = '0;
      outcome.status = STATUS_OK;
      // map_blocks of 0 counts as one block, anything above the maximum saturates
      nblk = (reg_blocks == 0) ? 1 : (reg_blocks > BLOCKS_MAX) ? BLOCKS_MAX : int'(reg_blocks);
      case (cmd.operation)
         OP_ALLOC: begin
            hint = int'(cmd.bit_index);
            if (hint >= reg_total) hint = 0;
            blk = hint >> BLOCK_BITS_LOG2;
            w = (hint - (blk << BLOCK_BITS_LOG2)) / WORD_BITS;
            if (blk >= nblk || w >= WORDS_PER_BLOCK) begin
               blk = 0;
               w = 0;
            end
            // a mid-block start revisits its own block from word 0 at the end
            count = (w == 0) ? nblk : nblk + 1;
            found = 1'b0;
            spot = 0;
            addr = 0;
            pos = 0;
            while (count > 0 && !found) begin
               count--;
               skip = 1'b0;
               while (w < WORDS_PER_BLOCK && !found && !skip) begin
                  addr = blk * WORDS_PER_BLOCK + w;
                  word = shadow_map[addr];
                  if (word != FULL_WORD) begin
                     pos = 0;
                     while (word[pos]) pos++;
                     spot = pos + w * WORD_BITS + (blk << BLOCK_BITS_LOG2);
                     // first clear bit at or past the total ends this block's scan
                     if (spot >= reg_total) begin
                        skip = 1'b1;
                     end else begin
                        shadow_map[addr][pos] = 1'b1;
                        shadow_dirty[blk] = 1'b1;
                        found = 1'b1;
                     end
                  end
                  w++;
               end
               if (!found) begin
                  blk++;
                  if (blk == nblk) blk = 0;
                  w = 0;
               end
            end
            if (!found) begin
               outcome.status = STATUS_NO_SPACE;
            end else if (spot < reg_first) begin
               // below the first data bit: handed back, dirty mark stays
               shadow_map[addr][pos] = 1'b0;
               outcome.status = STATUS_NO_SPACE;
            end else begin
               outcome.bit_number = BIT_W'(spot);
            end
         end
         OP_FREE: begin
            blk = int'(cmd.bit_index) >> BLOCK_BITS_LOG2;
            addr = int'(cmd.bit_index) / WORD_BITS;
            pos = int'(cmd.bit_index) % WORD_BITS;
            if (cmd.bit_index == 0) begin
               outcome.status = STATUS_IGNORED;
            end else if (cmd.bit_index < reg_first || cmd.bit_index >= reg_total
                         || blk >= nblk) begin
               outcome.status = STATUS_INVALID;
            end else if (!shadow_map[addr][pos]) begin
               outcome.status = STATUS_FREE_FREE;
            end else begin
               shadow_map[addr][pos] = 1'b0;
               shadow_dirty[blk] = 1'b1;
            end
         end
         OP_LOAD: begin
            shadow_map[cmd.word_index] = cmd.word_data;
         end
         OP_READ: begin
            outcome.read_data = shadow_map[cmd.word_index];
            outcome.block_dirty = shadow_dirty[int'(cmd.word_index) / WORDS_PER_BLOCK];
         end
      endcase
      return outcome;
   endfunction

   task automatic queue_cmd(input logic [OP_W-1:0] op, input int bit_idx, input int widx,
                            input logic [DATA_W-1:0] data, input bit hold);
      pending_cmd_type entry;
      entry.cmd.operation  = op;
      entry.cmd.bit_index  = BIT_W'(bit_idx);
      entry.cmd.word_index = WORD_INDEX_W'(widx);
      entry.cmd.word_data  = data;
      entry.hold = hold;
      cmd_queue.push_back(entry);
      // several times the slowest legal handling of this command plus the longest gap
      cycle_limit += (op == OP_ALLOC) ? 4 * (SCAN_CYCLES + 16) : 4 * 16;
   endtask

   // Waits, at falling edges, until nothing is queued, outstanding or in progress.
   task automatic settle();
      do @(negedge clock);
      while (cmd_queue.size() != 0 || awaited_outcomes.size() != 0 || busy !== 1'b0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= CSR_DATA_W'(data);
      case (idx)
         CSR_TOTAL_BITS:     reg_total  = TOTAL_W'(data);
         CSR_MAP_BLOCKS:     reg_blocks = MAPBLK_W'(data);
         CSR_FIRST_DATA_BIT: reg_first  = FIRST_W'(data);
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Registers change only with the block idle and nothing outstanding.
   task automatic configure(input int total, input int blocks, input int first);
      settle();
      write_csr(CSR_TOTAL_BITS, total);
      write_csr(CSR_MAP_BLOCKS, blocks);
      write_csr(CSR_FIRST_DATA_BIT, first);
      csr_write_en <= 1'b0;
      cycle_limit += 200;
   endtask

   // Driver: presents the head of the queue from a falling edge; idles in random bursts
   // straight after a request transfer so gaps land at every point of the block's work.
   always @(negedge clock) begin
      if (just_taken) begin
         just_taken = 1'b0;
         if (idling_on && $urandom_range(2) == 0) gap_left = $urandom_range(6, 1);
      end
      if (reset || gap_left > 0 || cmd_queue.size() == 0) begin
         start <= 1'b0;
         if (gap_left > 0) gap_left--;
      end else if (cmd_queue[0].hold && (awaited_outcomes.size() != 0 || busy !== 1'b0)) begin
         // held command: the allocator must drain completely first
         start <= 1'b0;
      end else begin
         start       <= 1'b1;
         req_payload <= cmd_queue[0].cmd;
      end
   end

   // Monitor: checks each result transfer against the oldest outcome, then records
   // any request transfer at this edge.
   always @(posedge clock) begin
      rsp_type         want;
      pending_cmd_type taken;
      if (!reset) begin
         if (rsp_strobe !== 1'b0) begin
            if (awaited_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing outstanding, actual %h", $time, rsp_payload);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_payload.status !== want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_payload.status);
               end
               if (rsp_payload.bit_number !== want.bit_number) begin
                  error_count++;
                  $display("%0t: bit_number expected %0d actual %0d",
                           $time, want.bit_number, rsp_payload.bit_number);
               end
               if (rsp_payload.read_data !== want.read_data) begin
                  error_count++;
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_payload.read_data);
               end
               if (rsp_payload.block_dirty !== want.block_dirty) begin
                  error_count++;
                  $display("%0t: block_dirty expected %b actual %b",
                           $time, want.block_dirty, rsp_payload.block_dirty);
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0 && cmd_queue.size() != 0) begin
            taken = cmd_queue.pop_front();
            awaited_outcomes.push_back(zone_outcome(taken.cmd));
            just_taken = 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      int phase, b, nblk, t, f, k, base, placed, r, hint;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values written explicitly: an empty map (total 0).
      configure(0, 1, 0);
      // Whole map loaded first so no scan ever touches an unwritten word;
      // three words in four full to lengthen scans.
      for (int i = 0; i < MAP_WORDS; i++)
         queue_cmd(OP_LOAD, 0, i,
                   (i == 0) ? '0 : ($urandom_range(3) != 0 ? FULL_WORD : $urandom()), 1'b0);
      queue_cmd(OP_ALLOC, 0, 0, '0, 1'b0);          // no space with total 0
      queue_cmd(OP_FREE, 0, 0, '0, 1'b0);           // free of zero is ignored
      queue_cmd(OP_FREE, 1, 0, '0, 1'b0);           // past the total
      queue_cmd(OP_READ, 0, 0, '0, 1'b0);
      queue_cmd(OP_READ, 0, MAP_WORDS - 1, '0, 1'b0);

      // Largest map, every block in use.
      configure(65536, BLOCKS_MAX, 0);
      idling_on = 1'b1;
      queue_cmd(OP_LOAD, 0, 5, FULL_WORD, 1'b0);
      queue_cmd(OP_FREE, 5 * WORD_BITS + 3, 0, '0, 1'b0);
      queue_cmd(OP_FREE, 5 * WORD_BITS + 3, 0, '0, 1'b1);   // freeing a free bit, after a drain
      queue_cmd(OP_ALLOC, 5 * WORD_BITS + 3, 0, '0, 1'b0);
      queue_cmd(OP_ALLOC, 65535, 0, '0, 1'b0);              // hint in the last word of the map
      queue_cmd(OP_FREE, 65535, 0, '0, 1'b0);
      queue_cmd(OP_READ, 0, MAP_WORDS - 1, '0, 1'b0);

      // Small map with a reserved low region: allocation below the first data bit.
      configure(100, 1, 40);
      for (int i = 0; i < 4; i++) queue_cmd(OP_LOAD, 0, i, '0, 1'b0);
      queue_cmd(OP_ALLOC, 0, 0, '0, 1'b0);
      queue_cmd(OP_ALLOC, 5000, 0, '0, 1'b0);   // hint past the total restarts at bit 0
      queue_cmd(OP_ALLOC, 64, 0, '0, 1'b0);
      queue_cmd(OP_FREE, 10, 0, '0, 1'b0);      // below the first data bit
      queue_cmd(OP_FREE, 100, 0, '0, 1'b0);     // at the total
      queue_cmd(OP_READ, 0, 0, '0, 1'b0);

      // map_blocks 0 behaves as one block: hint and free in an unused block.
      configure(20000, 0, 0);
      queue_cmd(OP_ALLOC, 17000, 0, '0, 1'b0);
      queue_cmd(OP_FREE, 17000, 0, '0, 1'b0);

      // map_blocks saturates; everything below the first data bit.
      configure(65535, 15, 65535);
      queue_cmd(OP_ALLOC, 0, 0, '0, 1'b0);

      // Random phases, each under its own register setting.
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         b = $urandom_range(15);
         nblk = (b == 0) ? 1 : (b > BLOCKS_MAX) ? BLOCKS_MAX : b;
         case ($urandom_range(3))
            0: t = $urandom_range(65536);
            1: t = nblk * (1 << BLOCK_BITS_LOG2) - $urandom_range(200);
            2: t = $urandom_range(nblk - 1) * (1 << BLOCK_BITS_LOG2) + $urandom_range(300);
            default: t = 65536;
         endcase
         f = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(t / 8);
         configure(t, b, f);
         // last phase runs flat out
         idling_on = (phase < RAND_PHASES - 1);
         placed = 0;
         while (placed < PHASE_CMDS) begin
            r = $urandom_range(99);
            if (r < 12) begin
               // fill a run of words, then allocate from inside it: forces longer scans
               k = $urandom_range(12, 1);
               base = $urandom_range(nblk * WORDS_PER_BLOCK - 1);
               for (int j = 0; j < k; j++)
                  queue_cmd(OP_LOAD, 0, (base + j) % MAP_WORDS, FULL_WORD, 1'b0);
               queue_cmd(OP_ALLOC, base * WORD_BITS + $urandom_range(WORD_BITS - 1), 0, '0,
                         $urandom_range(29) == 0);
               placed += k + 1;
            end else if (r < 45) begin
               hint = ($urandom_range(3) == 0 || t == 0) ? $urandom_range(65535)
                                                         : $urandom_range(t - 1);
               queue_cmd(OP_ALLOC, hint, $urandom_range(MAP_WORDS - 1), $urandom(),
                         $urandom_range(29) == 0);
               placed++;
            end else if (r < 70) begin
               case ($urandom_range(7))
                  0:       hint = 0;
                  1, 2:    hint = $urandom_range(65535);
                  default: hint = $urandom_range((t > f) ? t - 1 : f, f);
               endcase
               queue_cmd(OP_FREE, hint, $urandom_range(MAP_WORDS - 1), $urandom(),
                         $urandom_range(29) == 0);
               placed++;
            end else if (r < 85) begin
               queue_cmd(OP_LOAD, $urandom_range(65535), $urandom_range(MAP_WORDS - 1),
                         $urandom_range(1) ? FULL_WORD : $urandom(), 1'b0);
               placed++;
            end else begin
               queue_cmd(OP_READ, $urandom_range(65535), $urandom_range(MAP_WORDS - 1),
                         $urandom(), 1'b0);
               placed++;
            end
         end
      end

      settle();
      repeat (8) @(negedge clock);
      if (error_count == 0 && awaited_outcomes.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
